[design/ptm_pkg.sv]
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types, codes and helpers for the page table map and translate block.
// ----------------------------------------------------------------------------
package ptm_pkg;

	localparam int unsigned PAGE_OFFSET_BITS     = 12;
	localparam int unsigned PAGE_NUMBER_BITS_DEF = 10;
	localparam int unsigned FRAME_BITS           = 32 - PAGE_OFFSET_BITS;
	localparam int unsigned COUNT_BITS           = FRAME_BITS + 1;
	localparam logic [31:0] FRAME_MASK           = 32'hfffff000;

	typedef enum logic [2:0] {
		CMD_INIT_IDENTITY = 3'd0,
		CMD_WRITE_ENTRY   = 3'd1,
		CMD_MAP_RANGE     = 3'd2,
		CMD_MAP_TO        = 3'd3,
		CMD_READ_ENTRY    = 3'd4,
		CMD_TRANSLATE     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK             = 2'd0,
		STAT_MISALIGNED     = 2'd1,
		STAT_END_BEFORE     = 2'd2,
		STAT_OUT_OF_RANGE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_WRITE,
		ACT_INIT,
		ACT_RUN,
		ACT_READ
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_RUN,
		ST_READ
	} state_t;

	typedef struct packed {
		status_t                status;
		act_t                   act;
		logic                   xlat;
		logic [COUNT_BITS-1:0]  count;
	} chk_t;

	function automatic logic page_in_store(logic [FRAME_BITS-1:0] vpage, int unsigned pnb);
		return (vpage >> pnb) == '0;
	endfunction

endpackage

[design/ptm_check.sv]
// ----------------------------------------------------------------------------
// ptm_check
// Command decode and argument checks: alignment, ordering and store range.
// ----------------------------------------------------------------------------
module ptm_check #(
	parameter int unsigned PAGE_NUMBER_BITS = ptm_pkg::PAGE_NUMBER_BITS_DEF
) (
	input  logic [2:0]                      command,
	input  logic [31:0]                     vaddr,
	input  logic [31:0]                     phys_addr,
	input  logic [31:0]                     phys_limit,
	input  logic [ptm_pkg::COUNT_BITS-1:0]  page_count,
	output ptm_pkg::chk_t                   chk
);

	localparam int unsigned OFF = ptm_pkg::PAGE_OFFSET_BITS;

	logic        virt_mis;
	logic        phys_mis;
	logic        end_mis;
	logic        virt_in;
	logic [31:0] span;

	assign virt_mis = vaddr[OFF-1:0] != '0;
	assign phys_mis = phys_addr[OFF-1:0] != '0;
	assign end_mis  = phys_limit[OFF-1:0] != '0;
	assign virt_in  = ptm_pkg::page_in_store(vaddr[31:OFF], PAGE_NUMBER_BITS);
	assign span     = phys_limit - phys_addr;

	always_comb begin
		chk.status = ptm_pkg::STAT_OK;
		chk.act    = ptm_pkg::ACT_NONE;
		chk.xlat   = 1'b0;
		chk.count  = page_count;
		case (ptm_pkg::cmd_t'(command))
			ptm_pkg::CMD_INIT_IDENTITY: begin
				chk.act = ptm_pkg::ACT_INIT;
			end
			ptm_pkg::CMD_WRITE_ENTRY: begin
				if (virt_mis)
					chk.status = ptm_pkg::STAT_MISALIGNED;
				else if (!virt_in)
					chk.status = ptm_pkg::STAT_OUT_OF_RANGE;
				else
					chk.act = ptm_pkg::ACT_WRITE;
			end
			ptm_pkg::CMD_MAP_RANGE: begin
				if (page_count == '0)
					chk.act = ptm_pkg::ACT_NONE;
				else if (virt_mis || phys_mis)
					chk.status = ptm_pkg::STAT_MISALIGNED;
				else
					chk.act = ptm_pkg::ACT_RUN;
			end
			ptm_pkg::CMD_MAP_TO: begin
				chk.count = {1'b0, span[31:OFF]};
				if (virt_mis || phys_mis || end_mis)
					chk.status = ptm_pkg::STAT_MISALIGNED;
				else if (phys_limit < phys_addr)
					chk.status = ptm_pkg::STAT_END_BEFORE;
				else
					chk.act = ptm_pkg::ACT_RUN;
			end
			ptm_pkg::CMD_READ_ENTRY: begin
				if (virt_mis)
					chk.status = ptm_pkg::STAT_MISALIGNED;
				else if (!virt_in)
					chk.status = ptm_pkg::STAT_OUT_OF_RANGE;
				else
					chk.act = ptm_pkg::ACT_READ;
			end
			ptm_pkg::CMD_TRANSLATE: begin
				chk.xlat = 1'b1;
				if (!virt_in)
					chk.status = ptm_pkg::STAT_OUT_OF_RANGE;
				else
					chk.act = ptm_pkg::ACT_READ;
			end
			default: begin
				chk.act = ptm_pkg::ACT_NONE;
			end
		endcase
	end

endmodule

[design/page_table_map_and_translate.sv]
// ----------------------------------------------------------------------------
// page_table_map_and_translate
// Flat page entry store with identity init, raw write, run maps, read and
// address translation.
// ----------------------------------------------------------------------------
// One command is in flight at a time; the next transfer is taken once the
// previous result has been delivered. Errors, unused commands and write_entry
// present their result in the cycle after acceptance. read_entry and translate
// register the store read and then the result (synchronous store read).
// map_range and map_to write one page per cycle through the single store write
// port and present their result once the run ends; init_identity writes all
// 2^PAGE_NUMBER_BITS entries. Store contents are undefined after reset until
// written.
module page_table_map_and_translate #(
	parameter int unsigned PAGE_NUMBER_BITS = ptm_pkg::PAGE_NUMBER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      command,
	input  logic [31:0]                     vaddr,
	input  logic [31:0]                     phys_addr,
	input  logic [31:0]                     phys_limit,
	input  logic [ptm_pkg::COUNT_BITS-1:0]  page_count,
	input  logic [11:0]                     page_flags,
	input  logic [31:0]                     entry_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [31:0]                     entry_value,
	output logic [31:0]                     translated_addr
);

	localparam int unsigned OFF   = ptm_pkg::PAGE_OFFSET_BITS;
	localparam int unsigned FB    = ptm_pkg::FRAME_BITS;
	localparam int unsigned CB    = ptm_pkg::COUNT_BITS;
	localparam int unsigned DEPTH = 1 << PAGE_NUMBER_BITS;

	ptm_pkg::state_t  state_q, state_d;
	ptm_pkg::chk_t    chk;

	logic [CB-1:0]    run_pos_q, run_pos_d;
	logic [CB-1:0]    count_q, count_d;
	logic [FB-1:0]    vpage_q, vpage_d;
	logic [FB-1:0]    frame_q, frame_d;
	logic [11:0]      flags_q, flags_d;
	logic [OFF-1:0]   off_q, off_d;
	logic             xlat_cmd_q, xlat_cmd_d;

	logic             out_valid_q;
	ptm_pkg::status_t status_q;
	logic [31:0]      value_q;
	logic [31:0]      taddr_q;

	logic             res_load;
	ptm_pkg::status_t res_status;
	logic [31:0]      res_value;
	logic [31:0]      res_taddr;

	logic [31:0]                 store_mem [DEPTH];
	logic [31:0]                 rd_data_q;
	logic                        mem_we;
	logic [PAGE_NUMBER_BITS-1:0] mem_idx;
	logic [31:0]                 mem_wdata;
	logic [PAGE_NUMBER_BITS-1:0] rd_idx;

	logic accept;

	assign in_stall = (state_q != ptm_pkg::ST_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;
	assign rd_idx   = vaddr[OFF +: PAGE_NUMBER_BITS];

	ptm_check #(
		.PAGE_NUMBER_BITS(PAGE_NUMBER_BITS)
	) u_check (
		.command   (command),
		.vaddr     (vaddr),
		.phys_addr (phys_addr),
		.phys_limit(phys_limit),
		.page_count(page_count),
		.chk       (chk)
	);

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[mem_idx] <= mem_wdata;
		rd_data_q <= store_mem[rd_idx];
	end

	always_comb begin
		state_d    = state_q;
		run_pos_d  = run_pos_q;
		count_d    = count_q;
		vpage_d    = vpage_q;
		frame_d    = frame_q;
		flags_d    = flags_q;
		off_d      = off_q;
		xlat_cmd_d = xlat_cmd_q;
		mem_we     = 1'b0;
		mem_idx    = '0;
		mem_wdata  = '0;
		res_load   = 1'b0;
		res_status = ptm_pkg::STAT_OK;
		res_value  = '0;
		res_taddr  = '0;
		case (state_q)
			ptm_pkg::ST_IDLE: begin
				if (accept) begin
					run_pos_d  = '0;
					count_d    = chk.count;
					vpage_d    = vaddr[31:OFF];
					frame_d    = phys_addr[31:OFF];
					flags_d    = page_flags;
					off_d      = vaddr[OFF-1:0];
					xlat_cmd_d = chk.xlat;
					case (chk.act)
						ptm_pkg::ACT_WRITE: begin
							mem_we     = 1'b1;
							mem_idx    = rd_idx;
							mem_wdata  = entry_data;
							res_load   = 1'b1;
						end
						ptm_pkg::ACT_INIT: state_d = ptm_pkg::ST_INIT;
						ptm_pkg::ACT_RUN:  state_d = ptm_pkg::ST_RUN;
						ptm_pkg::ACT_READ: state_d = ptm_pkg::ST_READ;
						default: begin
							res_load   = 1'b1;
							res_status = chk.status;
						end
					endcase
				end
			end
			ptm_pkg::ST_INIT: begin
				if (run_pos_q == CB'(DEPTH)) begin
					res_load  = 1'b1;
					run_pos_d = '0;
					state_d   = ptm_pkg::ST_IDLE;
				end else begin
					mem_we    = 1'b1;
					mem_idx   = run_pos_q[PAGE_NUMBER_BITS-1:0];
					mem_wdata = {run_pos_q[FB-1:0], flags_q};
					run_pos_d = run_pos_q + 1'b1;
				end
			end
			ptm_pkg::ST_RUN: begin
				if (run_pos_q == count_q) begin
					res_load  = 1'b1;
					run_pos_d = '0;
					state_d   = ptm_pkg::ST_IDLE;
				end else if (!ptm_pkg::page_in_store(vpage_q, PAGE_NUMBER_BITS)) begin
					res_load   = 1'b1;
					res_status = ptm_pkg::STAT_OUT_OF_RANGE;
					run_pos_d  = '0;
					state_d    = ptm_pkg::ST_IDLE;
				end else begin
					mem_we    = 1'b1;
					mem_idx   = vpage_q[PAGE_NUMBER_BITS-1:0];
					mem_wdata = {frame_q, flags_q};
					vpage_d   = vpage_q + 1'b1;
					frame_d   = frame_q + 1'b1;
					run_pos_d = run_pos_q + 1'b1;
				end
			end
			ptm_pkg::ST_READ: begin
				res_load  = 1'b1;
				res_value = rd_data_q;
				if (xlat_cmd_q)
					res_taddr = (rd_data_q & ptm_pkg::FRAME_MASK) | {{FB{1'b0}}, off_q};
				state_d   = ptm_pkg::ST_IDLE;
			end
			default: begin
				state_d = ptm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptm_pkg::ST_IDLE;
			run_pos_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			run_pos_q <= run_pos_d;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		count_q    <= count_d;
		vpage_q    <= vpage_d;
		frame_q    <= frame_d;
		flags_q    <= flags_d;
		off_q      <= off_d;
		xlat_cmd_q <= xlat_cmd_d;
		if (res_load) begin
			status_q <= res_status;
			value_q  <= res_value;
			taddr_q  <= res_taddr;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign entry_value     = value_q;
	assign translated_addr = taddr_q;

	// a result only appears after a transfer in or while a command is busy
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past((state_q != ptm_pkg::ST_IDLE) || accept))
		else $error("result without a pending command");

	// no result is held while the store is still being worked on
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ptm_pkg::ST_IDLE) |-> !out_valid_q)
		else $error("result pending during busy state");

	// run position returns to zero between commands
	a_pos_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptm_pkg::ST_IDLE) |-> (run_pos_q == '0))
		else $error("run position not cleared");

	// a run never passes its page count
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptm_pkg::ST_RUN) |-> (run_pos_q <= count_q))
		else $error("run position beyond count");

endmodule
